// ----- rtl/rtti_pkg.sv -----
// Shared types, constants and helper functions for the radix text to integer unit.
`default_nettype none

package rtti_pkg;

   localparam int CharWidth  = 21;
   localparam int RadixWidth = 6;
   localparam int ValueWidth = 64;

   // Parser phases.
   localparam logic [2:0] PhaseLead  = 3'd0;
   localparam logic [2:0] PhaseSign  = 3'd1;
   localparam logic [2:0] PhaseDigit = 3'd2;
   localparam logic [2:0] PhaseTrail = 3'd3;
   localparam logic [2:0] PhaseFail  = 3'd4;

   localparam logic [CharWidth-1:0] CharSpace  = 21'h000020;
   localparam logic [CharWidth-1:0] CharMinus  = 21'h00002D;
   localparam logic [CharWidth-1:0] CharZero   = 21'h000030;
   localparam logic [CharWidth-1:0] CharNine   = 21'h000039;
   localparam logic [CharWidth-1:0] CharLowerA = 21'h000061;
   localparam logic [CharWidth-1:0] CharLowerF = 21'h000066;
   localparam logic [CharWidth-1:0] CharUpperA = 21'h000041;
   localparam logic [CharWidth-1:0] CharUpperF = 21'h000046;

   localparam logic [RadixWidth-1:0] RadixTwo     = 6'd2;
   localparam logic [RadixWidth-1:0] RadixTen     = 6'd10;
   localparam logic [RadixWidth-1:0] RadixSixteen = 6'd16;

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 has_char;
      logic                 last;
   } req_payload_type;

   typedef struct packed {
      logic                         ok;
      logic signed [ValueWidth-1:0] value;
      logic                         overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic logic radix_good(input logic [RadixWidth-1:0] radix);
      return (radix == RadixTwo) || (radix == RadixTen) || (radix == RadixSixteen);
   endfunction

   // Digit value of a character in the given radix; valid is low for a non-digit.
   function automatic digit_type decode_digit(input logic [CharWidth-1:0] ch,
                                              input logic [RadixWidth-1:0] radix);
      digit_type            result;
      logic [CharWidth-1:0] offset;
      logic [4:0]           raw;
      result = '0;
      raw    = '0;
      offset = '0;
      if (ch >= CharZero && ch <= CharNine) begin
         offset       = ch - CharZero;
         raw          = offset[4:0];
         result.valid = 1'b1;
      end else if (ch >= CharLowerA && ch <= CharLowerF) begin
         offset       = ch - CharLowerA;
         raw          = offset[4:0] + 5'd10;
         result.valid = 1'b1;
      end else if (ch >= CharUpperA && ch <= CharUpperF) begin
         offset       = ch - CharUpperA;
         raw          = offset[4:0] + 5'd10;
         result.valid = 1'b1;
      end
      if ({1'b0, raw} >= radix) begin
         result.valid = 1'b0;
      end
      result.value = raw[3:0];
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rtti_channel_if.sv -----
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none

interface rtti_channel_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/radix_text_to_integer_unit.sv -----
// Top level of the radix text to integer unit: string parser and result register.
`default_nettype none

// Converts a string, one character per transaction with the final one marked by last,
// into a signed 64-bit integer in the base held in the radix register (2, 10 or 16).
// One transaction is taken every cycle unless the input register stalls: each character
// passes an input register and is folded into the running accumulator in the next cycle,
// where the multiply by the radix is a shift-and-add feeding a 69-bit sum whose upper bits
// flag a wrap. A last-marked transaction's result is then held in a result register; the
// input register only stalls when a result is still waiting and the next is a last one.
// The radix register resets to 10 and must be written only while the unit is idle.
module radix_text_to_integer_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   rtti_channel_if.sink                      req_channel,
   rtti_channel_if.source                    rsp_channel,
   input  wire logic                         csr_write_enable,
   input  wire logic [rtti_pkg::RadixWidth-1:0] csr_write_data
);

   localparam int SumWidth = rtti_pkg::ValueWidth + 5;

   logic [rtti_pkg::RadixWidth-1:0] radix_ff;
   logic                            in_valid_ff, in_valid_in;
   rtti_pkg::req_payload_type       in_payload_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   rtti_pkg::rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic [2:0]                      phase_ff, phase_in;
   logic                            negative_ff, negative_in;
   logic [rtti_pkg::ValueWidth-1:0] acc_ff, acc_in;
   logic                            wrapped_ff, wrapped_in;

   logic [2:0]                      step_phase;
   logic                            step_negative;
   logic [rtti_pkg::ValueWidth-1:0] step_acc;
   logic                            step_wrapped;

   logic                            advance;
   logic                            take_req;
   logic                            radix_is_good;
   logic                            is_space;
   logic                            is_minus;
   rtti_pkg::digit_type             digit;
   logic [SumWidth-1:0]             acc_ext;
   logic [SumWidth-1:0]             product;
   logic [SumWidth-1:0]             sum;
   logic                            good;

   // Characters that produce no result always move on; a last one needs room downstream.
   assign advance  = in_valid_ff &&
                     (!in_payload_ff.last || !rsp_valid_ff || rsp_channel.ready);
   assign take_req = req_channel.valid && req_channel.ready;

   assign req_channel.ready   = !in_valid_ff || advance;
   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_payload_ff;

   assign radix_is_good = rtti_pkg::radix_good(radix_ff);
   assign is_space      = (in_payload_ff.ch == rtti_pkg::CharSpace);
   assign is_minus      = (in_payload_ff.ch == rtti_pkg::CharMinus);
   assign digit         = rtti_pkg::decode_digit(in_payload_ff.ch, radix_ff);
   assign acc_ext       = {5'd0, acc_ff};

   always_comb begin
      unique case (radix_ff)
         rtti_pkg::RadixTwo:     product = acc_ext << 1;
         rtti_pkg::RadixTen:     product = (acc_ext << 3) + (acc_ext << 1);
         rtti_pkg::RadixSixteen: product = acc_ext << 4;
         default:                product = '0;
      endcase
   end

   assign sum = product + {{(SumWidth-4){1'b0}}, digit.value};

   always_comb begin
      step_phase    = phase_ff;
      step_negative = negative_ff;
      step_acc      = acc_ff;
      step_wrapped  = wrapped_ff;
      if (in_payload_ff.has_char && phase_ff != rtti_pkg::PhaseFail) begin
         if (!radix_is_good) begin
            step_phase = rtti_pkg::PhaseFail;
         end else begin
            unique case (phase_ff)
               rtti_pkg::PhaseLead: begin
                  priority if (is_space) begin
                     step_phase = rtti_pkg::PhaseLead;
                  end else if (is_minus) begin
                     step_negative = 1'b1;
                     step_phase    = rtti_pkg::PhaseSign;
                  end else if (digit.valid) begin
                     step_acc     = sum[rtti_pkg::ValueWidth-1:0];
                     step_wrapped = wrapped_ff || (|sum[SumWidth-1:rtti_pkg::ValueWidth]);
                     step_phase   = rtti_pkg::PhaseDigit;
                  end else begin
                     step_phase = rtti_pkg::PhaseFail;
                  end
               end
               rtti_pkg::PhaseSign, rtti_pkg::PhaseDigit: begin
                  priority if (digit.valid) begin
                     step_acc     = sum[rtti_pkg::ValueWidth-1:0];
                     step_wrapped = wrapped_ff || (|sum[SumWidth-1:rtti_pkg::ValueWidth]);
                     step_phase   = rtti_pkg::PhaseDigit;
                  end else if (is_space) begin
                     step_phase = rtti_pkg::PhaseTrail;
                  end else begin
                     step_phase = rtti_pkg::PhaseFail;
                  end
               end
               rtti_pkg::PhaseTrail: begin
                  if (!is_space) begin
                     step_phase = rtti_pkg::PhaseFail;
                  end
               end
               default: step_phase = rtti_pkg::PhaseFail;
            endcase
         end
      end
   end

   assign good = radix_is_good &&
                 (step_phase == rtti_pkg::PhaseDigit || step_phase == rtti_pkg::PhaseTrail);

   always_comb begin
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      acc_in         = acc_ff;
      wrapped_in     = wrapped_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_channel.ready;
      in_valid_in    = in_valid_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         if (in_payload_ff.last) begin
            // The string ends here: emit its result and start the next one clean.
            rsp_valid_in            = 1'b1;
            rsp_payload_in.ok       = good;
            rsp_payload_in.value    = !good ? '0 :
                                      (step_negative ? -step_acc : step_acc);
            rsp_payload_in.overflow = good && step_wrapped;
            phase_in                = rtti_pkg::PhaseLead;
            negative_in             = 1'b0;
            acc_in                  = '0;
            wrapped_in              = 1'b0;
         end else begin
            phase_in    = step_phase;
            negative_in = step_negative;
            acc_in      = step_acc;
            wrapped_in  = step_wrapped;
         end
      end
      if (take_req) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= rtti_pkg::RadixTen;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= rtti_pkg::PhaseLead;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         wrapped_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         acc_ff       <= acc_in;
         wrapped_ff   <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_payload_ff <= req_channel.payload;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire
